// ----- rtl/core/slr_pkg.sv -----
// Shared types and constants of the PWM slew limiter.
`timescale 1ns / 1ps
`default_nettype none
package slr_pkg;

   localparam int MAX_CHANNELS = 8;
   localparam int DUTY_W       = 16;
   localparam int CSR_INDEX_W  = 2;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_STEP   = 2'd0,
      CSR_LOW_LIMIT  = 2'd1,
      CSR_HIGH_LIMIT = 2'd2,
      CSR_NEUTRAL    = 2'd3
   } csr_index_type;

   // Reset duty by channel.
   localparam logic [DUTY_W-1:0] DUTY_RESET [MAX_CHANNELS] = '{
      16'd14800, 16'd12000, 16'd12000, 16'd9200,
      16'd12000, 16'd12000, 16'd12000, 16'd12000
   };

   localparam logic [DUTY_W-1:0] MAX_STEP_RESET   = 16'd200;
   localparam logic [DUTY_W-1:0] LOW_LIMIT_RESET  = 16'd2000;
   localparam logic [DUTY_W-1:0] HIGH_LIMIT_RESET = 16'd22000;
   localparam logic [DUTY_W-1:0] NEUTRAL_RESET    = 16'd12000;

   typedef struct packed {
      logic [DUTY_W-1:0] max_step;
      logic [DUTY_W-1:0] low_limit;
      logic [DUTY_W-1:0] high_limit;
      logic [DUTY_W-1:0] neutral;
   } cfg_type;

endpackage
`default_nettype wire

// ----- rtl/core/slr_frame_front.sv -----
// Byte assembler: collects frame bytes and pushes each complete frame.
`timescale 1ns / 1ps
`default_nettype none
module slr_frame_front #(
   parameter int CHANNELS = 4
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             byte_valid,
   output logic                            byte_ready,
   input  wire  [7:0]                      rx_byte,
   input  wire                             frame_start,
   output logic                            push,
   output logic [CHANNELS*slr_pkg::DUTY_W-1:0] frame,
   input  wire                             queue_full
);
   localparam int FRAME_BYTES = 2 * CHANNELS;
   localparam int POS_W       = $clog2(FRAME_BYTES);

   logic [POS_W-1:0] pos_ff, pos_in, pos_eff;
   logic [7:0]       store_ff [FRAME_BYTES];
   logic             accept, last_byte;

   assign byte_ready = !queue_full;
   assign accept     = byte_valid && byte_ready;
   // A frame start forces the byte to position zero.
   assign pos_eff    = frame_start ? '0 : pos_ff;
   assign last_byte  = (pos_eff == POS_W'(FRAME_BYTES - 1));
   assign push       = accept && last_byte;
   assign pos_in     = last_byte ? '0 : pos_eff + POS_W'(1);

   // The final byte bypasses the store straight into the pushed frame.
   always_comb begin
      for (int i = 0; i < FRAME_BYTES - 1; i++) begin
         frame[8*i +: 8] = store_ff[i];
      end
      frame[8*(FRAME_BYTES-1) +: 8] = rx_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         store_ff[pos_eff] <= rx_byte;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/core/slr_frame_fifo.sv -----
// Two-entry queue of assembled frames between front and back.
`timescale 1ns / 1ps
`default_nettype none
module slr_frame_fifo #(
   parameter int WIDTH = 64
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  wire  [WIDTH-1:0] push_data,
   output logic             full,
   input  wire              pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);
   logic [WIDTH-1:0] entry_ff [2];
   logic [1:0]       count_ff, count_in;
   logic             wr_ptr_ff, rd_ptr_ff;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/core/slr_slew_back.sv -----
// Range check, slew limiting, duty state and result register.
`timescale 1ns / 1ps
`default_nettype none
module slr_slew_back #(
   parameter int CHANNELS = 4
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  slr_pkg::cfg_type                    cfg,
   input  wire                                 frame_valid,
   input  wire  [CHANNELS*slr_pkg::DUTY_W-1:0] frame,
   output logic                                frame_pop,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic [4*slr_pkg::DUTY_W-1:0]        rsp_duty,
   output logic                                rsp_gear
);
   localparam int MAXC = slr_pkg::MAX_CHANNELS;
   localparam int DW   = slr_pkg::DUTY_W;

   logic [DW-1:0] last_duty_ff [CHANNELS];
   logic [DW-1:0] req_w   [MAXC];
   logic [DW-1:0] prev_w  [MAXC];
   logic [DW-1:0] slewed  [MAXC];
   logic [DW-1:0] out_w   [MAXC];
   logic [CHANNELS-1:0] upd;
   logic          all_ok, gear_w, out_free;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [4*DW-1:0] rsp_duty_ff;
   logic          rsp_gear_ff;

   function automatic logic [DW-1:0] slew_one(input logic [DW-1:0] prev,
                                              input logic [DW-1:0] req,
                                              input logic [DW-1:0] step);
      logic [DW-1:0] dn, up, res;
      dn  = prev - req;
      up  = req - prev;
      res = req;
      if (prev == '0) begin
         res = req;
      end else if (prev > req && dn > step) begin
         res = prev - step;
      end else if (prev < req && up > step) begin
         res = prev + step;
      end
      return res;
   endfunction

   // Pad channel views to the full width so absent channels read as zero.
   for (genvar g = 0; g < MAXC; g++) begin : g_pad
      if (g < CHANNELS) begin : g_on
         assign req_w[g]  = frame[DW*g +: DW];
         assign prev_w[g] = last_duty_ff[g];
      end else begin : g_off
         assign req_w[g]  = '0;
         assign prev_w[g] = '0;
      end
   end

   always_comb begin
      for (int i = 0; i < MAXC; i++) begin
         slewed[i] = slew_one(prev_w[i], req_w[i], cfg.max_step);
      end
   end

   // Update channels up to the first request out of range.
   always_comb begin
      logic ok;
      ok = 1'b1;
      for (int i = 0; i < CHANNELS; i++) begin
         if (req_w[i] < cfg.low_limit || req_w[i] > cfg.high_limit) begin
            ok = 1'b0;
         end
         upd[i] = ok;
      end
      all_ok = ok;
   end

   always_comb begin
      for (int i = 0; i < MAXC; i++) begin
         out_w[i] = (i < CHANNELS) ? slewed[i] : '0;
      end
   end

   assign gear_w = (CHANNELS > 2) && (req_w[1] == cfg.neutral) &&
                   (req_w[2] == cfg.neutral);

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign frame_pop    = frame_valid && out_free;
   assign rsp_valid_in = frame_pop ? all_ok : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            last_duty_ff[i] <= slr_pkg::DUTY_RESET[i];
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < CHANNELS; i++) begin
            if (frame_pop && upd[i]) begin
               last_duty_ff[i] <= slewed[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (frame_pop && all_ok) begin
         rsp_duty_ff <= {out_w[3], out_w[2], out_w[1], out_w[0]};
         rsp_gear_ff <= gear_w;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_duty  = rsp_duty_ff;
   assign rsp_gear  = rsp_gear_ff;
endmodule
`default_nettype wire

// ----- rtl/core/four_channel_pwm_slew_limiter.sv -----
// The last byte pushes its frame into the queue; the back end registers each result.
// Throughput: one byte request per cycle while the queue has room; the back end retires
// one frame per cycle while its result register is free. The byte assembler and the
// slew stage run apart through a two-frame queue. Reset (synchronous, active high)
// clears byte position, queue and output valid and loads per-channel duty and register defaults.
`timescale 1ns / 1ps
`default_nettype none
module four_channel_pwm_slew_limiter #(
   parameter int CHANNELS = 4
) (
   input  wire         clock,
   input  wire         reset,
   // Request stream: one frame byte per request.
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire         req_tuser,   // [0] frame_start
   // Result stream: one result per accepted frame with every request in range.
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [71:0] rsp_tdata,   // [15:0] duty_a, [31:16] duty_b, [47:32] duty_c,
                                    // [63:48] duty_d, [64] gear_neutral, [71:65] zero
   // Register write port.
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [15:0] csr_data
);
   localparam int DW    = slr_pkg::DUTY_W;
   localparam int FRM_W = CHANNELS * DW;

   slr_pkg::cfg_type cfg_ff;
   logic             push, queue_full, frame_valid, frame_pop;
   logic [FRM_W-1:0] frame_in, frame_out;
   logic [4*DW-1:0]  rsp_duty;
   logic             rsp_gear;

   // Registers are always writable; the user must write them only while idle, the block does not enforce it.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_step   <= slr_pkg::MAX_STEP_RESET;
         cfg_ff.low_limit  <= slr_pkg::LOW_LIMIT_RESET;
         cfg_ff.high_limit <= slr_pkg::HIGH_LIMIT_RESET;
         cfg_ff.neutral    <= slr_pkg::NEUTRAL_RESET;
      end else if (csr_valid && csr_ready) begin
         case (slr_pkg::csr_index_type'(csr_index))
            slr_pkg::CSR_MAX_STEP:   cfg_ff.max_step   <= csr_data;
            slr_pkg::CSR_LOW_LIMIT:  cfg_ff.low_limit  <= csr_data;
            slr_pkg::CSR_HIGH_LIMIT: cfg_ff.high_limit <= csr_data;
            slr_pkg::CSR_NEUTRAL:    cfg_ff.neutral    <= csr_data;
            default: ;
         endcase
      end
   end

   // Front: assemble bytes, push each complete frame.
   slr_frame_front #(.CHANNELS(CHANNELS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (req_tvalid),
      .byte_ready  (req_tready),
      .rx_byte     (req_tdata),
      .frame_start (req_tuser),
      .push        (push),
      .frame       (frame_in),
      .queue_full  (queue_full)
   );

   // Queue: hold up to two frames so either side can stall.
   slr_frame_fifo #(.WIDTH(FRM_W)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (frame_in),
      .full      (queue_full),
      .pop       (frame_pop),
      .not_empty (frame_valid),
      .pop_data  (frame_out)
   );

   // Back: check ranges, limit slew, advance duty state, register result.
   slr_slew_back #(.CHANNELS(CHANNELS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .frame_valid (frame_valid),
      .frame       (frame_out),
      .frame_pop   (frame_pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_duty    (rsp_duty),
      .rsp_gear    (rsp_gear)
   );

   assign rsp_tdata = {7'd0, rsp_gear, rsp_duty};
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the four-channel PWM slew limiter.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

   // Cycles to let pass after the last result before touching the registers;
   // an aborted frame leaves no result behind but may still be in flight.
   localparam int SETTLE_CYCLES = 8;
   localparam int FRAME_LEN     = 8;

   // Receiver back-pressure styles.
   typedef enum int {
      STALL_NONE,
      STALL_COIN,
      STALL_EVERY_FOURTH,
      STALL_LONG
   } stall_style_type;

   // One result: four duties and the gear flag.
   typedef struct packed {
      logic              gear;
      logic [3:0][15:0]  duty;
   } duty_set_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [7:0]  req_tdata = '0;     // [7:0] rx_byte
   logic        req_tuser = 1'b0;   // [0] frame_start
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [71:0] rsp_tdata;          // [15:0] duty_a, [31:16] duty_b, [47:32] duty_c,
                                    // [63:48] duty_d, [64] gear_neutral, [71:65] zero
   logic        csr_valid = 1'b0;
   wire         csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   // Predictor state: register copy, byte assembler and per-channel duty.
   slr_pkg::cfg_type cfg;
   int               frame_pos;
   logic [7:0]       frame_bytes [FRAME_LEN];
   logic [15:0]      duty_now [4];
   duty_set_type     duty_expect_q [$];

   int              error_count = 0;
   int              items_sent = 0;
   int              burst_left = 0;
   int              gap_max = 0;
   stall_style_type stall_mode = STALL_NONE;
   int              stall_tick = 0;
   int              stall_hold = 0;

   string       duty_name [4] = '{"duty_a", "duty_b", "duty_c", "duty_d"};

   four_channel_pwm_slew_limiter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Move a duty toward its target by at most max_step; a zero duty jumps.
   function automatic logic [15:0] slew_toward(logic [15:0] prev, logic [15:0] target);
      logic [15:0] down;
      logic [15:0] up;
      down = prev - target;
      up   = target - prev;
      if (prev == 16'd0) return target;
      if (prev > target && down > cfg.max_step) return prev - cfg.max_step;
      if (prev < target && up > cfg.max_step) return prev + cfg.max_step;
      return target;
   endfunction

   // Absorb one accepted request byte; queue a result when a frame passes.
   function automatic void absorb_byte(logic [7:0] rx_byte, logic frame_start);
      logic [15:0]  want [4];
      duty_set_type res;
      if (frame_start) frame_pos = 0;
      frame_bytes[frame_pos] = rx_byte;
      frame_pos++;
      if (frame_pos < FRAME_LEN) return;
      frame_pos = 0;
      for (int ch = 0; ch < 4; ch++) want[ch] = {frame_bytes[2*ch+1], frame_bytes[2*ch]};
      // Channels are committed in order; the first out-of-range request stops it all.
      for (int ch = 0; ch < 4; ch++) begin
         if (want[ch] < cfg.low_limit || want[ch] > cfg.high_limit) return;
         duty_now[ch] = slew_toward(duty_now[ch], want[ch]);
      end
      for (int ch = 0; ch < 4; ch++) res.duty[ch] = duty_now[ch];
      res.gear = (want[1] == cfg.neutral) && (want[2] == cfg.neutral);
      duty_expect_q.push_back(res);
   endfunction

   // ------------------------------------------------------------------
   // Result checker
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      duty_set_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (duty_expect_q.size() == 0) begin
            $error("unexpected result %h", rsp_tdata);
            error_count++;
         end else begin
            want = duty_expect_q.pop_front();
            for (int ch = 0; ch < 4; ch++) begin
               if (rsp_tdata[16*ch +: 16] !== want.duty[ch]) begin
                  $error("%s: expected %0d, got %0d", duty_name[ch], want.duty[ch],
                         rsp_tdata[16*ch +: 16]);
                  error_count++;
               end
            end
            if (rsp_tdata[64] !== want.gear) begin
               $error("gear_neutral: expected %0d, got %0d", want.gear, rsp_tdata[64]);
               error_count++;
            end
            if (rsp_tdata[71:65] !== 7'd0) begin
               $error("reserved bits: expected 0, got %h", rsp_tdata[71:65]);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver back-pressure
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         stall_tick++;
         case (stall_mode)
            STALL_NONE: begin
               rsp_tready <= 1'b1;
            end
            STALL_COIN: begin
               rsp_tready <= 1'($urandom_range(0, 1));
            end
            STALL_EVERY_FOURTH: begin
               rsp_tready <= (stall_tick % 4 == 0);
            end
            default: begin
               // Alternate long stalls with short ready windows.
               if (stall_hold > 0) begin
                  stall_hold--;
               end else begin
                  rsp_tready <= ~rsp_tready;
                  stall_hold = rsp_tready ? $urandom_range(5, 40) : $urandom_range(0, 6);
               end
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Send one request; idle first when the current burst is used up.
   task automatic send_byte(logic [7:0] rx_byte, logic frame_start);
      int gap;
      if (burst_left == 0) begin
         gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx_byte;
      req_tuser  <= frame_start;
      do @(posedge clock); while (!req_tready);
      absorb_byte(rx_byte, frame_start);
      items_sent++;
      burst_left--;
   endtask

   // Send a frame, low byte of each request first.
   task automatic send_frame(logic [3:0][15:0] reqs, bit with_start);
      for (int b = 0; b < FRAME_LEN; b++) begin
         send_byte(b[0] ? reqs[b/2][15:8] : reqs[b/2][7:0], with_start && b == 0);
      end
   endtask

   // Hold off the sender until every pending result is out, then settle.
   task automatic drain_results(int settle);
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (duty_expect_q.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_reg(slr_pkg::csr_index_type idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         slr_pkg::CSR_MAX_STEP:   cfg.max_step   = value;
         slr_pkg::CSR_LOW_LIMIT:  cfg.low_limit  = value;
         slr_pkg::CSR_HIGH_LIMIT: cfg.high_limit = value;
         slr_pkg::CSR_NEUTRAL:    cfg.neutral    = value;
         default: ;
      endcase
   endtask

   // Rewrite all registers while the block is idle.
   task automatic set_config(logic [15:0] step, logic [15:0] lo, logic [15:0] hi,
                             logic [15:0] neut);
      drain_results(SETTLE_CYCLES);
      write_reg(slr_pkg::CSR_MAX_STEP, step);
      write_reg(slr_pkg::CSR_LOW_LIMIT, lo);
      write_reg(slr_pkg::CSR_HIGH_LIMIT, hi);
      write_reg(slr_pkg::CSR_NEUTRAL, neut);
      csr_valid <= 1'b0;
   endtask

   // Pick a request that mostly passes the limits, often near the current duty.
   function automatic logic [15:0] pick_request(int ch);
      int          roll;
      logic [15:0] near;
      roll = $urandom_range(0, 99);
      near = duty_now[ch] + 16'($urandom_range(0, 600)) - 16'd300;
      if (roll < 4) return cfg.low_limit;
      if (roll < 8) return cfg.high_limit;
      if (roll < 25 && (ch == 1 || ch == 2)) return cfg.neutral;
      if (roll < 94 && cfg.low_limit <= cfg.high_limit) begin
         if (roll < 50 && near >= cfg.low_limit && near <= cfg.high_limit) return near;
         return 16'($urandom_range(int'(cfg.high_limit), int'(cfg.low_limit)));
      end
      return 16'($urandom_range(0, 65535));
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Hand-picked frames at the default registers.
   task automatic test_directed_frames();
      stall_mode = STALL_COIN;
      gap_max = 2;
      // Clamp on channel 0 and 3 within step, gear set by neutral on 1 and 2.
      send_frame({16'd9000, 16'd12000, 16'd12000, 16'd15500}, 1'b1);
      // Abandon a partial frame; the next frame start restarts assembly.
      send_byte(8'hA5, 1'b1);
      send_byte(8'h5A, 1'b0);
      send_byte(8'h3C, 1'b0);
      send_frame({16'd11999, 16'd12000, 16'd22000, 16'd2000}, 1'b1);
      // Abort at channel 2 with all-ones bytes, all-zeros bytes behind it.
      send_frame({16'h0000, 16'hFFFF, 16'd12001, 16'd16000}, 1'b1);
      // No frame start: position wrapped after the abort; channel 3 one above high.
      send_frame({16'd22001, 16'd2001, 16'd12000, 16'd21999}, 1'b0);
   endtask

   // Drive duties to zero, then show that a zero duty takes its request directly.
   task automatic test_zero_duty();
      set_config(16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
      send_frame('0, 1'b1);
      set_config(16'd0, 16'd0, 16'hFFFF, 16'd0);
      send_frame({16'd40000, 16'd1, 16'd65535, 16'd7}, 1'b1);
      // With max_step zero every nonzero duty holds.
      send_frame({16'd0, 16'd0, 16'd0, 16'd0}, 1'b1);
   endtask

   // Crossed and equal limits.
   task automatic test_limit_edges();
      set_config(16'd200, 16'hFFFF, 16'd0, 16'd12000);
      send_frame({16'd12000, 16'd12000, 16'd12000, 16'd12000}, 1'b1);
      send_frame({16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000}, 1'b1);
      set_config(16'd500, 16'd12345, 16'd12345, 16'd12345);
      send_frame({16'd12345, 16'd12345, 16'd12345, 16'd12345}, 1'b1);
      send_frame({16'd12345, 16'd12345, 16'd12346, 16'd12345}, 1'b1);
      send_frame({16'd12344, 16'd12345, 16'd12345, 16'd12345}, 1'b1);
   endtask

   // Mostly well-formed frames with random content, plus noise and broken frames.
   task automatic run_random_phase(int n);
      int               first;
      int               roll;
      int               cnt;
      logic [3:0][15:0] reqs;
      first = items_sent;
      while (items_sent - first < n) begin
         roll = $urandom_range(0, 99);
         for (int ch = 0; ch < 4; ch++) reqs[ch] = pick_request(ch);
         if (roll < 2) begin
            // Wait until every pending result is out before going on.
            drain_results(0);
         end else if (roll < 72) begin
            send_frame(reqs, 1'b1);
         end else if (roll < 80) begin
            send_frame(reqs, 1'b0);
         end else if (roll < 90) begin
            cnt = $urandom_range(1, FRAME_LEN - 1);
            for (int b = 0; b < cnt; b++) begin
               send_byte(b[0] ? reqs[b/2][15:8] : reqs[b/2][7:0], b == 0);
            end
         end else begin
            cnt = $urandom_range(1, 4);
            repeat (cnt) send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 2) == 0));
         end
      end
   endtask

   task automatic test_random();
      logic [15:0] lo;
      // Defaults, with coin-flip stalls and short gaps.
      stall_mode = STALL_COIN;
      gap_max = 3;
      set_config(slr_pkg::MAX_STEP_RESET, slr_pkg::LOW_LIMIT_RESET,
                 slr_pkg::HIGH_LIMIT_RESET, slr_pkg::NEUTRAL_RESET);
      run_random_phase(340);
      // Full range, frozen duties; no idling on either side.
      stall_mode = STALL_NONE;
      gap_max = 0;
      set_config(16'd0, 16'd0, 16'hFFFF, 16'd0);
      run_random_phase(340);
      // Unlimited step in a narrow window.
      stall_mode = STALL_EVERY_FOURTH;
      gap_max = 1;
      set_config(16'hFFFF, 16'd1000, 16'd3000, 16'd2000);
      run_random_phase(340);
      // Random registers under long stalls and long gaps.
      stall_mode = STALL_LONG;
      gap_max = 8;
      lo = 16'($urandom_range(0, 20000));
      set_config(16'($urandom_range(0, 1000)), lo, lo + 16'($urandom_range(500, 40000)),
                 16'($urandom_range(int'(lo), int'(lo) + 500)));
      run_random_phase(340);
      // Single-value window at the top; duties creep by one.
      stall_mode = STALL_COIN;
      gap_max = 2;
      set_config(16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_random_phase(340);
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      cfg.max_step   = slr_pkg::MAX_STEP_RESET;
      cfg.low_limit  = slr_pkg::LOW_LIMIT_RESET;
      cfg.high_limit = slr_pkg::HIGH_LIMIT_RESET;
      cfg.neutral    = slr_pkg::NEUTRAL_RESET;
      frame_pos = 0;
      for (int ch = 0; ch < 4; ch++) duty_now[ch] = slr_pkg::DUTY_RESET[ch];
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_frames();
      test_zero_duty();
      test_limit_edges();
      test_random();

      drain_results(SETTLE_CYCLES + 2);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   // Watchdog: well above the slowest legal run.
   initial begin
      #10_000_000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
`default_nettype wire

// ----- sim.f -----
rtl/core/slr_pkg.sv
rtl/core/slr_frame_front.sv
rtl/core/slr_frame_fifo.sv
rtl/core/slr_slew_back.sv
rtl/core/four_channel_pwm_slew_limiter.sv
tb/testbench.sv
